[rtl/pru_pkg.sv]
// package for the packed residue unpacker
// holds the shared constants, the command record passed from front to back and the code select
// no dependencies
package pru_pkg;

    // field sizes
    localparam int CODE_BITS = 5;
    localparam int NUM_CODES = 6;
    localparam int CODES_W   = CODE_BITS * NUM_CODES;
    localparam int IDX_W     = 12;
    localparam int LEN_W     = 24;
    localparam int NRES_W    = 3;
    localparam int POS_W     = 3;
    localparam int TOTAL_W   = 4;

    // codes and limits
    localparam logic [CODE_BITS-1:0] STOP_CODE    = 5'd31;
    localparam logic [LEN_W-1:0]     LEN_MAX      = 24'hFFFFFF;
    localparam logic [7:0]           SENTINEL_RST = 8'hFF;
    localparam int                   END_BIT      = 31;

    // sequence index saturation
    localparam int MAX_SEQS      = 4096;
    localparam int IDX_FIELD_MAX = 4095;
    localparam int IDX_LIMIT_INT = (MAX_SEQS - 1 < IDX_FIELD_MAX) ? MAX_SEQS - 1 : IDX_FIELD_MAX;
    localparam logic [IDX_W-1:0] IDX_LIMIT = IDX_LIMIT_INT[IDX_W-1:0];

    // command queue
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    // one classified request, ready for the back end to emit
    typedef struct packed {
        logic              lead;
        logic              is_end;
        logic [NRES_W-1:0] nres;
        logic [CODES_W-1:0] codes;
        logic [IDX_W-1:0]  index;
        logic [LEN_W-1:0]  length;
    } cmd_t;

    // code r counted from the top field down
    function automatic logic [CODE_BITS-1:0] code_at(input logic [CODES_W-1:0] codes,
                                                     input logic [NRES_W-1:0] r);
        logic [CODE_BITS-1:0] c;
        case (r)
            3'd0:    c = codes[29:25];
            3'd1:    c = codes[24:20];
            3'd2:    c = codes[19:15];
            3'd3:    c = codes[14:10];
            3'd4:    c = codes[9:5];
            3'd5:    c = codes[4:0];
            default: c = codes[4:0];
        endcase
        return c;
    endfunction

endpackage

[rtl/pru_if.sv]
// channel interfaces for the packed residue unpacker
// word channel in, result channel out; valid/ready handshake
// no dependencies
interface pru_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] packed_word;
    logic        chunk_start;

    modport source (output valid, output packed_word, output chunk_start, input ready);
    modport sink   (input valid, input packed_word, input chunk_start, output ready);
endinterface

interface pru_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  residue_byte;
    logic        is_sentinel;
    logic [11:0] seq_index;
    logic [23:0] seq_length;
    logic        last_of_run;

    modport source (output valid, output residue_byte, output is_sentinel, output seq_index,
                    output seq_length, output last_of_run, input ready);
    modport sink   (input valid, input residue_byte, input is_sentinel, input seq_index,
                    input seq_length, input last_of_run, output ready);
endinterface

[rtl/pru_front.sv]
// front end: accepts packed words, counts residues and sequences, builds commands
// depends on pru_pkg and pru_in_if
module pru_front (
    input  logic         clk,
    input  logic         rst_n,
    pru_in_if.sink       words,
    input  logic         q_full,
    output logic         q_push,
    output pru_pkg::cmd_t q_data
);
    import pru_pkg::*;

    logic [LEN_W-1:0]  count_reg, count_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [LEN_W-1:0]  count_base;
    logic [IDX_W-1:0]  idx_base;
    logic [LEN_W:0]    count_sum;
    logic [LEN_W-1:0]  count_sat;
    logic [NRES_W-1:0] nres;
    logic              is_end;
    logic              found;

    assign words.ready = !q_full;
    assign q_push      = words.valid && !q_full;
    assign is_end      = words.packed_word[END_BIT];

    // number of residues: all six, or up to the first stop code on an end word
    always_comb
    begin
        nres  = NRES_W'(NUM_CODES);
        found = 1'b0;
        if (is_end)
        begin
            for (int i = 0; i < NUM_CODES; i++)
            begin
                if (!found && code_at(words.packed_word[CODES_W-1:0], NRES_W'(i)) == STOP_CODE)
                begin
                    nres  = NRES_W'(i);
                    found = 1'b1;
                end
            end
        end
    end

    // counters after an optional chunk restart, then saturating update
    always_comb
    begin
        count_base = words.chunk_start ? '0 : count_reg;
        idx_base   = words.chunk_start ? '0 : idx_reg;
        count_sum  = {1'b0, count_base} + (LEN_W+1)'(nres);
        count_sat  = (count_sum > {1'b0, LEN_MAX}) ? LEN_MAX : count_sum[LEN_W-1:0];
        if (is_end)
        begin
            count_next = '0;
            idx_next   = (idx_base < IDX_LIMIT) ? idx_base + 1'b1 : idx_base;
        end
        else
        begin
            count_next = count_sat;
            idx_next   = idx_base;
        end
    end

    // command for the back end
    always_comb
    begin
        q_data.lead   = words.chunk_start;
        q_data.is_end = is_end;
        q_data.nres   = nres;
        q_data.codes  = words.packed_word[CODES_W-1:0];
        q_data.index  = idx_base;
        q_data.length = count_sat;
    end

    // counter state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            idx_reg   <= '0;
        end
        else if (q_push)
        begin
            count_reg <= count_next;
            idx_reg   <= idx_next;
        end
    end

endmodule

[rtl/pru_fifo.sv]
// command queue between front and back end
// depends on pru_pkg
module pru_fifo (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  pru_pkg::cmd_t wdata,
    input  logic          pop,
    output logic          full,
    output logic          empty,
    output pru_pkg::cmd_t head
);
    import pru_pkg::*;

    cmd_t                  mem_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [FIFO_CNT_W-1:0] cnt_reg, cnt_next;

    assign full  = (cnt_reg == FIFO_CNT_W'(FIFO_DEPTH));
    assign empty = (cnt_reg == '0);
    assign head  = mem_reg[rd_ptr_reg];

    // occupancy
    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop)
            cnt_next = cnt_reg + 1'b1;
        else if (pop && !push)
            cnt_next = cnt_reg - 1'b1;
    end

    // pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            cnt_reg <= cnt_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= wdata;
    end

endmodule

[rtl/pru_back.sv]
// back end: walks one command, one result a cycle while results is ready, into the output register
// depends on pru_pkg and pru_out_if
module pru_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          q_empty,
    input  pru_pkg::cmd_t q_head,
    output logic          q_pop,
    input  logic [7:0]    sentinel,
    pru_out_if.source     results
);
    import pru_pkg::*;

    logic [POS_W-1:0]   pos_reg, pos_next;
    logic               valid_reg, valid_next;
    logic [7:0]         byte_reg, byte_next;
    logic               sent_reg, sent_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic [LEN_W-1:0]   len_reg, len_next;
    logic               last_reg, last_next;
    logic [TOTAL_W-1:0] total;
    logic [TOTAL_W-1:0] rel;
    logic               load;
    logic               last;

    assign results.valid        = valid_reg;
    assign results.residue_byte = byte_reg;
    assign results.is_sentinel  = sent_reg;
    assign results.seq_index    = idx_reg;
    assign results.seq_length   = len_reg;
    assign results.last_of_run  = last_reg;

    // position within the current command
    assign total = TOTAL_W'(q_head.lead) + TOTAL_W'(q_head.nres) + TOTAL_W'(q_head.is_end);
    assign rel   = {1'b0, pos_reg} - TOTAL_W'(q_head.lead);
    assign last  = ({1'b0, pos_reg} == total - 1'b1);
    assign load  = !q_empty && (!valid_reg || results.ready);
    assign q_pop = load && last;

    // select the result at this position
    always_comb
    begin
        if (q_head.lead && pos_reg == '0)
        begin
            byte_next = sentinel;
            sent_next = 1'b1;
            idx_next  = '0;
            len_next  = '0;
        end
        else if (rel < {1'b0, q_head.nres})
        begin
            byte_next = {3'b000, code_at(q_head.codes, rel[NRES_W-1:0])};
            sent_next = 1'b0;
            idx_next  = q_head.index;
            len_next  = '0;
        end
        else
        begin
            byte_next = sentinel;
            sent_next = 1'b1;
            idx_next  = q_head.index;
            len_next  = q_head.length;
        end
        last_next = last;
        pos_next  = last ? '0 : pos_reg + 1'b1;
        if (load)
            valid_next = 1'b1;
        else if (results.ready)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            pos_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (load)
                pos_reg <= pos_next;
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            byte_reg <= byte_next;
            sent_reg <= sent_next;
            idx_reg  <= idx_next;
            len_reg  <= len_next;
            last_reg <= last_next;
        end
    end

endmodule

[rtl/packed_residue_unpacker.sv]
// top level of the packed residue unpacker: front end, command queue, back end, sentinel register
// depends on pru_pkg, pru_if, pru_front, pru_fifo, pru_back
//
//   channel    dir   handshake          payload
//   words      in    valid/ready        packed_word[31:0], chunk_start
//   results    out   valid/ready        residue_byte[7:0], is_sentinel, seq_index[11:0],
//                                       seq_length[23:0], last_of_run
//   sentinel   in    sentinel_we        sentinel_wdata[7:0]
//
// the back end emits one result a cycle while results is ready; a word yields 1 to 8 results there
// (6 for a middle word with no lead sentinel, 7 with one),
// counted from the lead sentinel, the residues and the trailing sentinel it causes
// the front end takes one word a cycle while the 4-entry command queue has room
// reset clears the counters, the queue and the output valid flag; the sentinel returns to 255
// a stall on results holds the output register and fills the queue, then drops words.ready
module packed_residue_unpacker (
    input  logic       clk,
    input  logic       rst_n,
    pru_in_if.sink     words,
    pru_out_if.source  results,
    input  logic       sentinel_we,
    input  logic [7:0] sentinel_wdata
);
    import pru_pkg::*;

    logic [7:0] sentinel_reg;
    logic       q_push, q_pop, q_full, q_empty;
    cmd_t       q_wdata, q_head;

    // sentinel configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sentinel_reg <= SENTINEL_RST;
        else if (sentinel_we)
            sentinel_reg <= sentinel_wdata;
    end

    // classify words and keep the counters
    pru_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .words  (words),
        .q_full (q_full),
        .q_push (q_push),
        .q_data (q_wdata)
    );

    // decoupling queue
    pru_fifo u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata (q_wdata),
        .pop   (q_pop),
        .full  (q_full),
        .empty (q_empty),
        .head  (q_head)
    );

    // emit results
    pru_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_empty  (q_empty),
        .q_head   (q_head),
        .q_pop    (q_pop),
        .sentinel (sentinel_reg),
        .results  (results)
    );

endmodule
